// File: rtl/sit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths, defaults and result codes of the string intern table.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int unsigned ENTRIES_DEF   = 128;
  localparam int unsigned KEY_BYTES_DEF = 128;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [ST_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

endpackage

// File: rtl/sit_key_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_key_if
// Request channel carrying one key byte per transfer.
// ----------------------------------------------------------------------------
interface sit_key_if;
  logic                     valid;
  logic                     ready;
  logic [sit_pkg::KEY_W-1:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

// File: rtl/sit_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_res_if
// Result channel carrying entry index and status of one lookup.
// ----------------------------------------------------------------------------
interface sit_res_if;
  logic                     valid;
  logic                     ready;
  logic [sit_pkg::IDX_W-1:0] entry_index;
  logic [sit_pkg::ST_W-1:0]  status;

  modport source (output valid, output entry_index, output status, input ready);
  modport sink   (input valid, input entry_index, input status, output ready);
endinterface

// File: rtl/string_intern_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_intern_table_core
// Interns zero-terminated keys: linear search over stored entries, append on
// miss, error status on full table or over-long key.
// ----------------------------------------------------------------------------
//   port    dir  payload                      note
//   key_i   in   key_byte[7:0]                0 ends the key
//   res_o   out  entry_index[6:0], status[1:0] one result per terminator
//
// a nonzero key byte is pushed into the key buffer; a terminator walks the
// entry memory: each entry's length is read, and where it matches the bytes
// are compared; a miss writes the length and copies the new key in, then the result is loaded.
// no clearing pass after reset; stored entries are valid up to the count.
// key bytes are taken while a result waits; the next terminator's result
// waits in the final state until the output register is free.
// ----------------------------------------------------------------------------
module string_intern_table_core #(
  parameter int unsigned ENTRIES   = sit_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BYTES = sit_pkg::KEY_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sit_key_if.sink   key_i,
  sit_res_if.source res_o
);

  localparam int unsigned LW = $clog2(KEY_BYTES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned AW = $clog2(ENTRIES * KEY_BYTES);
  localparam int unsigned DW = (LW > sit_pkg::KEY_W) ? LW : sit_pkg::KEY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LEN,
    S_CMP,
    S_COPY,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   ent_q, ent_d;
  logic [AW-1:0]   base_q, base_d;
  logic [AW-1:0]   wa_q, wa_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [CW-1:0]   ridx_q, ridx_d;
  sit_pkg::status_e rst_q, rst_d;
  logic            outv_q, outv_d;
  logic [sit_pkg::IDX_W-1:0] oidx_q, oidx_d;
  sit_pkg::status_e ost_q, ost_d;

  logic [DW-1:0]   mem [ENTRIES * KEY_BYTES];
  logic [DW-1:0]   em_rdata_q;
  logic [AW-1:0]   em_raddr;
  logic [AW-1:0]   em_waddr;
  logic [DW-1:0]   em_wdata;
  logic            em_we;

  logic            kb_push;
  logic            kb_clear;
  logic [LW-1:0]   kb_raddr;
  logic [sit_pkg::KEY_W-1:0] kb_rdata;
  logic [LW-1:0]   klen;
  logic            kovf;

  logic            key_acc;
  logic [AW-1:0]   byte_addr;

  sit_key_buf #(
    .KEY_BYTES (KEY_BYTES)
  ) u_key_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (kb_push),
    .byte_i  (key_i.key_byte),
    .clear_i (kb_clear),
    .raddr_i (kb_raddr),
    .rdata_o (kb_rdata),
    .len_o   (klen),
    .ovf_o   (kovf)
  );

  assign key_i.ready = (state_q == S_IDLE);
  assign key_acc     = key_i.valid && key_i.ready;
  assign byte_addr   = base_q + AW'(idx_q) + AW'(1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ent_d    = ent_q;
    base_d   = base_q;
    wa_d     = wa_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    ridx_d   = ridx_q;
    rst_d    = rst_q;
    outv_d   = outv_q && !res_o.ready;
    oidx_d   = oidx_q;
    ost_d    = ost_q;
    em_we    = 1'b0;
    em_waddr = wa_q;
    em_wdata = DW'(kb_rdata);
    em_raddr = base_q;
    kb_push  = 1'b0;
    kb_clear = 1'b0;
    kb_raddr = idx_q;

    case (state_q)
      S_IDLE: begin
        if (key_acc) begin
          if (key_i.key_byte != '0) begin
            kb_push = 1'b1;
          end else if (kovf) begin
            ridx_d  = '0;
            rst_d   = sit_pkg::ST_TOO_LONG;
            state_d = S_DONE;
          end else begin
            ent_d   = '0;
            base_d  = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ent_q == cnt_q) begin
          if (cnt_q == CW'(ENTRIES)) begin
            ridx_d  = '0;
            rst_d   = sit_pkg::ST_FULL;
            state_d = S_DONE;
          end else begin
            em_we    = 1'b1;
            em_waddr = base_q;
            em_wdata = DW'(klen);
            cnt_d    = cnt_q + 1'b1;
            ridx_d   = cnt_q;
            rst_d    = sit_pkg::ST_INSERTED;
            idx_d    = '0;
            pend_d   = 1'b0;
            state_d  = S_COPY;
          end
        end else begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (em_rdata_q == DW'(klen)) begin
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = S_CMP;
        end else begin
          ent_d   = ent_q + 1'b1;
          base_d  = base_q + AW'(KEY_BYTES);
          state_d = S_SCAN;
        end
      end
      S_CMP: begin
        em_raddr = byte_addr;
        if (pend_q && (em_rdata_q != DW'(kb_rdata))) begin
          ent_d   = ent_q + 1'b1;
          base_d  = base_q + AW'(KEY_BYTES);
          state_d = S_SCAN;
        end else if (idx_q == klen) begin
          ridx_d  = ent_q;
          rst_d   = sit_pkg::ST_FOUND;
          state_d = S_DONE;
        end else begin
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end
      end
      S_COPY: begin
        if (pend_q) begin
          em_we = 1'b1;
        end
        if (idx_q == klen) begin
          state_d = S_DONE;
        end else begin
          wa_d   = byte_addr;
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!outv_q || res_o.ready) begin
          outv_d   = 1'b1;
          oidx_d   = sit_pkg::IDX_W'(ridx_q);
          ost_d    = rst_q;
          kb_clear = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    base_q <= base_d;
    wa_q   <= wa_d;
    idx_q  <= idx_d;
    ridx_q <= ridx_d;
    rst_q  <= rst_d;
    oidx_q <= oidx_d;
    ost_q  <= ost_d;
  end

  always_ff @(posedge clk_i) begin
    if (em_we) begin
      mem[em_waddr] <= em_wdata;
    end
    em_rdata_q <= mem[em_raddr];
  end

  assign res_o.valid       = outv_q;
  assign res_o.entry_index = oidx_q;
  assign res_o.status      = ost_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRIES))
    else $error("entry count beyond table size");

  a_err_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outv_q && (ost_q == sit_pkg::ST_FULL || ost_q == sit_pkg::ST_TOO_LONG))
      |-> (oidx_q == '0))
    else $error("error result with nonzero index");

  a_idx_in_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_COPY) |-> (idx_q <= klen))
    else $error("byte index ran past key length");

endmodule

// File: rtl/sit_key_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_key_buf
// Collects the bytes of the key in progress, tracks its length and overflow.
// ----------------------------------------------------------------------------
module sit_key_buf #(
  parameter int unsigned KEY_BYTES = sit_pkg::KEY_BYTES_DEF,
  localparam int unsigned LW = $clog2(KEY_BYTES)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [sit_pkg::KEY_W-1:0] byte_i,
  input  logic                      clear_i,
  input  logic [LW-1:0]             raddr_i,
  output logic [sit_pkg::KEY_W-1:0] rdata_o,
  output logic [LW-1:0]             len_o,
  output logic                      ovf_o
);

  logic [sit_pkg::KEY_W-1:0] mem [KEY_BYTES];
  logic [LW-1:0]             len_q, len_d;
  logic                      ovf_q, ovf_d;
  logic                      room;
  logic [sit_pkg::KEY_W-1:0] rdata_q;

  assign room = (len_q < LW'(KEY_BYTES - 1));

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (clear_i) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else if (push_i) begin
      if (room) begin
        len_d = len_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && room) begin
      mem[len_q] <= byte_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign len_o   = len_q;
  assign ovf_o   = ovf_q;

  a_no_push_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && clear_i))
    else $error("key push and clear in the same cycle");

  a_full_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !clear_i && !room) |=> ovf_q && $stable(len_q))
    else $error("push into a full key buffer did not flag overflow");

endmodule

// File: tb/tb_string_intern_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_intern_table_core
// Self-checking bench for the string intern table. Key bytes are streamed in
// through the request channel. A local model of the table predicts the entry
// index and status for each terminator. Each returned result is checked
// against the oldest prediction. Traffic covers directed edge keys, a
// receiver hold-off that backs up the input, a table fill past capacity and
// random keys, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_string_intern_table_core;

  localparam int unsigned ENTRIES      = sit_pkg::ENTRIES_DEF;
  localparam int unsigned KEY_BYTES    = sit_pkg::KEY_BYTES_DEF;
  localparam int unsigned KW           = sit_pkg::KEY_W;
  localparam int unsigned IW           = sit_pkg::IDX_W;
  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned POOL_MAX     = 512;
  localparam int unsigned DRAFT_MAX    = 2 * KEY_BYTES;

  typedef struct packed {
    logic [IW-1:0]    entry_index;
    sit_pkg::status_e status;
  } lookup_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic          key_valid = 1'b0;
  logic [KW-1:0] key_data  = '0;
  logic          res_ready = 1'b0;

  sit_key_if key_if ();
  sit_res_if res_if ();

  assign key_if.valid    = key_valid;
  assign key_if.key_byte = key_data;
  assign res_if.ready    = res_ready;

  string_intern_table_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_if),
    .res_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // model of the table
  logic [KW-1:0] tbl_bytes [0:ENTRIES-1][0:KEY_BYTES-1];
  int unsigned   tbl_len   [0:ENTRIES-1];
  int unsigned   tbl_count = 0;
  logic [KW-1:0] key_buf   [0:KEY_BYTES-1];
  int unsigned   key_len   = 0;
  bit            key_ovf   = 1'b0;

  lookup_t       expected_lookups [$];
  lookup_t       head_lookup;
  logic [KW-1:0] byte_queue [$];

  int unsigned bytes_queued  = 0;
  int unsigned bytes_taken   = 0;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  bit          key_fire      = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;

  // key generation
  logic [KW-1:0] draft_key [0:DRAFT_MAX-1];
  int unsigned   draft_len = 0;
  logic [KW-1:0] pool_key  [0:POOL_MAX-1][0:KEY_BYTES-1];
  int unsigned   pool_len  [0:POOL_MAX-1];
  int unsigned   pool_size = 0;

  function automatic void intern_key_byte(input logic [KW-1:0] b);
    lookup_t     res;
    bit          hit;
    bit          same;
    int unsigned e;
    int unsigned i;
    if (b != '0) begin
      if (key_len < KEY_BYTES - 1) begin
        key_buf[key_len] = b;
        key_len++;
      end else begin
        key_ovf = 1'b1;
      end
    end else begin
      hit = 1'b0;
      res.entry_index = '0;
      res.status = sit_pkg::ST_TOO_LONG;
      if (!key_ovf) begin
        for (e = 0; e < tbl_count && !hit; e++) begin
          if (tbl_len[e] == key_len) begin
            same = 1'b1;
            for (i = 0; i < key_len; i++) begin
              if (tbl_bytes[e][i] != key_buf[i]) same = 1'b0;
            end
            if (same) begin
              hit = 1'b1;
              res.entry_index = IW'(e);
            end
          end
        end
        if (hit) begin
          res.status = sit_pkg::ST_FOUND;
        end else if (tbl_count >= ENTRIES) begin
          res.status = sit_pkg::ST_FULL;
        end else begin
          for (i = 0; i < key_len; i++) tbl_bytes[tbl_count][i] = key_buf[i];
          tbl_len[tbl_count] = key_len;
          res.entry_index = IW'(tbl_count);
          res.status = sit_pkg::ST_INSERTED;
          tbl_count++;
        end
      end
      key_len = 0;
      key_ovf = 1'b0;
      expected_lookups.push_back(res);
    end
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      key_valid <= 1'b0;
    end else if (key_fire || !key_valid) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        key_data  <= byte_queue.pop_front();
        key_valid <= 1'b1;
      end else begin
        key_valid <= 1'b0;
      end
    end
  end

  // result backpressure, long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left--;
    end else begin
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_string_intern_table_core: done, errors");
      $finish;
    end else if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_lookups.size() == 0) begin
          $error("result with no request pending: entry_index %0d status %0d",
                 res_if.entry_index, res_if.status);
          error_count++;
        end else begin
          head_lookup = expected_lookups.pop_front();
          if (res_if.entry_index !== head_lookup.entry_index) begin
            $error("entry_index: expected %0d, got %0d",
                   head_lookup.entry_index, res_if.entry_index);
            error_count++;
          end
          if (res_if.status !== head_lookup.status) begin
            $error("status: expected %0d, got %0d", head_lookup.status, res_if.status);
            error_count++;
          end
        end
      end
      key_fire = key_if.valid && key_if.ready;
      if (key_fire) begin
        intern_key_byte(key_if.key_byte);
        bytes_taken++;
      end
    end
  end

  task automatic fill_draft(input int unsigned len);
    int unsigned i;
    draft_len = len;
    for (i = 0; i < len; i++) draft_key[i] = KW'($urandom_range(1, 255));
  endtask

  task automatic take_pool_key();
    int unsigned slot;
    int unsigned i;
    slot = $urandom_range(pool_size - 1);
    draft_len = pool_len[slot];
    for (i = 0; i < draft_len; i++) draft_key[i] = pool_key[slot][i];
  endtask

  task automatic queue_draft();
    int unsigned slot;
    int unsigned i;
    for (i = 0; i < draft_len; i++) byte_queue.push_back(draft_key[i]);
    byte_queue.push_back('0);
    bytes_queued += draft_len + 1;
    if (draft_len < KEY_BYTES) begin
      if (pool_size < POOL_MAX) begin
        slot = pool_size;
        pool_size++;
      end else begin
        slot = $urandom_range(POOL_MAX - 1);
      end
      pool_len[slot] = draft_len;
      for (i = 0; i < draft_len; i++) pool_key[slot][i] = draft_key[i];
    end
  endtask

  task automatic queue_short(input int unsigned len, input logic [KW-1:0] b0,
                             input logic [KW-1:0] b1);
    draft_len = len;
    draft_key[0] = b0;
    draft_key[1] = b1;
    queue_draft();
  endtask

  task automatic queue_random_keys(input int unsigned n, input int unsigned new_pct);
    int unsigned k;
    int unsigned pick;
    int unsigned j;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        fill_draft($urandom_range(KEY_BYTES, KEY_BYTES + 40));
      end else if (pick < new_pct) begin
        if ($urandom_range(9) == 0) fill_draft($urandom_range(7, KEY_BYTES - 1));
        else fill_draft($urandom_range(0, 6));
      end else begin
        take_pool_key();
        if (pick < new_pct + 15) begin
          // near miss of a stored key
          case ($urandom_range(2))
            0: begin
              if (draft_len > 0) begin
                j = $urandom_range(draft_len - 1);
                draft_key[j] = (draft_key[j] == 8'hFF) ? 8'h01 : draft_key[j] + 8'h01;
              end
            end
            1: begin
              if (draft_len < KEY_BYTES - 1) begin
                draft_key[draft_len] = KW'($urandom_range(1, 255));
                draft_len++;
              end
            end
            default: begin
              if (draft_len > 0) draft_len--;
            end
          endcase
        end
      end
      queue_draft();
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (bytes_taken != bytes_queued || expected_lookups.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned p;
    int unsigned i;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed keys
    @(posedge clk_i);
    queue_short(0, 8'h00, 8'h00);
    queue_short(0, 8'h00, 8'h00);
    queue_short(1, 8'h01, 8'h00);
    queue_short(1, 8'hFF, 8'h00);
    queue_short(2, 8'h80, 8'h7F);
    queue_short(1, 8'h01, 8'h00);
    queue_short(2, 8'h01, 8'hFF);
    queue_short(2, 8'hFF, 8'h01);
    fill_draft(KEY_BYTES - 1);
    queue_draft();
    queue_draft();
    fill_draft(KEY_BYTES);
    queue_draft();
    queue_short(0, 8'h00, 8'h00);
    settle();

    // receiver holds off while requests keep coming
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 12; i++) begin
      fill_draft($urandom_range(0, 4));
      queue_draft();
    end
    while (hold_left != 0) @(negedge clk_i);
    settle();

    for (p = 0; p < 6; p++) begin
      @(posedge clk_i);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 76;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 76;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct     = 35;
        end
      endcase
      if (p == 3) begin
        // push the table past capacity
        for (i = 0; i < 130; i++) begin
          queue_short(1, KW'(i + 1), 8'h00);
        end
      end else begin
        queue_random_keys(5, (p < 3) ? 45 : 35);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_lookups.size() != 0) begin
      $error("results still outstanding at end: %0d", expected_lookups.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb_string_intern_table_core: done, clean");
    end else begin
      $display("tb_string_intern_table_core: done, errors");
    end
    $finish;
  end

endmodule
